FILE: rtl/afe_pkg.sv
`timescale 1ns / 1ps

package afe_pkg;

   localparam int MAX_TERMS       = 6;
   localparam int NUM_TERMS_DEF   = 6;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int ARG_WIDTH       = 32;
   localparam int COEFF_WIDTH     = 64;
   localparam int RESULT_WIDTH    = 32;
   localparam int TERM_WIDTH      = 33;

   // quotient bits of b * 2^32 / D, which is at most 2^32
   localparam int DIV_STEPS  = 33;
   localparam int POW_STEPS  = 16;
   // stage 1, stage 2, division steps, multiply, sign
   localparam int LANE_LAT   = DIV_STEPS + 4;
   localparam int TOP_LAT    = LANE_LAT + 3;

   localparam logic [25:0] EXP2_SCALE = 26'd39238706;
   localparam logic signed [37:0] ONE_Q24 = 38'sd16777216;

   localparam logic REQ_GAUSSIAN   = 1'b0;
   localparam logic REQ_LORENTZIAN = 1'b1;

   typedef logic signed [TERM_WIDTH-1:0] term_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] rem;
      logic [63:0] root;
      logic [63:0] bit_v;
      rem   = v;
      root  = '0;
      bit_v = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (rem >= root + bit_v) begin
            rem  = rem - (root + bit_v);
            root = (root >> 1) + bit_v;
         end else begin
            root = root >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return root;
   endfunction

   // 2^(-2^(k-16)) in Q0.32
   function automatic logic [31:0] pow_entry(input int k);
      logic [63:0] t;
      t = isqrt64(64'h8000_0000_0000_0000);
      for (int j = 15; j > k; j--) begin
         t = isqrt64(t << 32);
      end
      return t[31:0];
   endfunction

endpackage

FILE: rtl/atomic_form_factor_eval_top.sv
`timescale 1ns / 1ps

// Atomic X-ray form factor unit: each request word carries a mode (Gaussian sum in q^2 or
// Lorentzian sum in v) and a Q16.16 argument, and returns one Q8.24 saturated result word
// with an overflow flag, in request order. It takes one word per clock while the result side
// does not stall; the pipeline depth is set by the one-bit-per-stage divider of the Lorentzian
// path inside each term lane; all terms run in parallel lanes. A one-word skid buffer at the
// input takes one more word while the result side stalls. Term registers are written through
// the csr port (always ready) and must only change while no request is in flight.
module atomic_form_factor_eval_top #(
   parameter int NUM_TERMS = afe_pkg::NUM_TERMS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_type,
   input  logic [afe_pkg::ARG_WIDTH-1:0]        req_argument,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [afe_pkg::RESULT_WIDTH-1:0] rsp_form_factor,
   output logic                                 rsp_overflow,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [afe_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [afe_pkg::COEFF_WIDTH-1:0]      csr_wdata
);

   localparam int LAT  = afe_pkg::TOP_LAT;

   // term registers
   logic [afe_pkg::COEFF_WIDTH-1:0] coeff_ff [NUM_TERMS];

   assign csr_ready = 1'b1;

   for (genvar i = 0; i < NUM_TERMS; i++) begin : g_csr
      always_ff @(posedge clock) begin
         if (reset) begin
            coeff_ff[i] <= '0;
         end else if (csr_valid && csr_index == afe_pkg::CSR_INDEX_WIDTH'(i)) begin
            coeff_ff[i] <= csr_wdata;
         end
      end
   end

   // input skid
   logic                          en;
   logic                          skid_valid_ff;
   logic                          skid_type_ff;
   logic [afe_pkg::ARG_WIDTH-1:0] skid_arg_ff;
   logic                          src_valid;
   logic                          src_type;
   logic [afe_pkg::ARG_WIDTH-1:0] src_arg;
   logic                          v_ff [LAT];
   logic                          m_ff [LAT];

   assign en        = !(v_ff[LAT-1] && rsp_stall);
   assign req_stall = skid_valid_ff;
   assign src_valid = skid_valid_ff || req_valid;
   assign src_type  = skid_valid_ff ? skid_type_ff : req_type;
   assign src_arg   = skid_valid_ff ? skid_arg_ff : req_argument;

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else if (en) begin
         skid_valid_ff <= 1'b0;
      end else if (req_valid && !skid_valid_ff) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!en && req_valid && !skid_valid_ff) begin
         skid_type_ff <= req_type;
         skid_arg_ff  <= req_argument;
      end
   end

   // valid and mode travel with the words
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LAT; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else if (en) begin
         v_ff[0] <= src_valid;
         for (int k = 1; k < LAT; k++) begin
            v_ff[k] <= v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff[0] <= src_type;
         for (int k = 1; k < LAT; k++) begin
            m_ff[k] <= m_ff[k-1];
         end
      end
   end

   // term lanes
   afe_pkg::term_type term_val [afe_pkg::MAX_TERMS];
   logic              term_ovf [afe_pkg::MAX_TERMS];

   for (genvar i = 0; i < afe_pkg::MAX_TERMS; i++) begin : g_lane
      if (i < NUM_TERMS) begin : g_on
         afe_lane u_lane (
            .clock    (clock),
            .en       (en),
            .in_arg   (src_arg),
            .in_type  (src_type),
            .coeff    (coeff_ff[i]),
            .term_out (term_val[i]),
            .ovf_out  (term_ovf[i])
         );
      end else begin : g_off
         assign term_val[i] = '0;
         assign term_ovf[i] = 1'b0;
      end
   end

   // adder tree
   logic signed [33:0] pair_ff [3];
   logic               povf_ff [3];
   logic signed [35:0] total_ff;
   logic               tovf_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            pair_ff[k] <= 34'(term_val[2*k]) + 34'(term_val[2*k+1]);
            povf_ff[k] <= term_ovf[2*k] || term_ovf[2*k+1];
         end
         total_ff <= 36'(pair_ff[0]) + 36'(pair_ff[1]) + 36'(pair_ff[2]);
         tovf_ff  <= povf_ff[0] || povf_ff[1] || povf_ff[2];
      end
   end

   logic signed [37:0] res;
   logic               sat_hi;
   logic               sat_lo;
   logic signed [afe_pkg::RESULT_WIDTH-1:0] ff_ff;
   logic                                    ovf_ff;

   assign res    = (m_ff[LAT-2] == afe_pkg::REQ_LORENTZIAN) ?
                   38'(total_ff) : afe_pkg::ONE_Q24 - 38'(total_ff);
   assign sat_hi = res > 38'sd2147483647;
   assign sat_lo = res < -38'sd2147483648;

   always_ff @(posedge clock) begin
      if (en) begin
         ff_ff  <= sat_hi ? 32'sh7FFF_FFFF : (sat_lo ? 32'sh8000_0000 : res[31:0]);
         ovf_ff <= tovf_ff || sat_hi || sat_lo;
      end
   end

   assign rsp_valid       = v_ff[LAT-1];
   assign rsp_form_factor = ff_ff;
   assign rsp_overflow    = ovf_ff;

endmodule

FILE: rtl/afe_lane.sv
`timescale 1ns / 1ps

module afe_lane (
   input  logic                  clock,
   input  logic                  en,
   input  logic [31:0]           in_arg,
   input  logic                  in_type,
   input  logic [63:0]           coeff,
   output afe_pkg::term_type     term_out,
   output logic                  ovf_out
);

   localparam int STEPS = afe_pkg::DIV_STEPS;

   logic [31:0] amp;
   logic [31:0] wid;
   logic        wid_zero;
   logic        neg;
   logic [31:0] mag;

   assign amp      = coeff[63:32];
   assign wid      = coeff[31:0];
   assign wid_zero = (wid == 32'd0);
   assign neg      = amp[31];
   assign mag      = neg ? (~amp + 32'd1) : amp;

   // stage 1
   logic [63:0] gp_ff;
   logic [63:0] xx_ff;
   logic        mode1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         gp_ff    <= {32'd0, in_arg} * {32'd0, wid};
         xx_ff    <= {32'd0, in_arg} * {32'd0, in_arg};
         mode1_ff <= in_type;
      end
   end

   // step pipeline, index 0 is stage 2
   logic [32:0] gf_ff   [STEPS+1];
   logic [25:0] y_ff    [STEPS+1];
   logic        big_ff  [STEPS+1];
   logic [48:0] d_ff    [STEPS+1];
   logic [48:0] rem_ff  [STEPS+1];
   logic [32:0] q_ff    [STEPS+1];
   logic        mode_ff [STEPS+1];

   logic [57:0] yp;
   assign yp = 58'(gp_ff[47:16]) * 58'(afe_pkg::EXP2_SCALE);

   always_ff @(posedge clock) begin
      if (en) begin
         gf_ff[0]   <= 33'h1_0000_0000;
         y_ff[0]    <= yp[57:32];
         big_ff[0]  <= (gp_ff[63:48] != 16'd0);
         d_ff[0]    <= 49'(wid) + 49'(xx_ff[63:16]);
         rem_ff[0]  <= 49'(wid[31:1]);
         q_ff[0]    <= '0;
         mode_ff[0] <= mode1_ff;
      end
   end

   for (genvar s = 1; s <= STEPS; s++) begin : g_step
      logic        nbit;
      logic [49:0] trial;
      logic        ge;
      logic [48:0] rem_in;
      logic [32:0] gf_in;

      assign nbit   = (s == 1) ? wid[0] : 1'b0;
      assign trial  = {rem_ff[s-1], nbit};
      assign ge     = (trial >= {1'b0, d_ff[s-1]});
      assign rem_in = ge ? 49'(trial - {1'b0, d_ff[s-1]}) : trial[48:0];

      if (s <= afe_pkg::POW_STEPS) begin : g_pow
         localparam logic [31:0] TK = afe_pkg::pow_entry(s - 1);
         logic [64:0] prod;
         assign prod  = 65'(gf_ff[s-1]) * 65'(TK);
         assign gf_in = y_ff[s-1][s-1] ? prod[64:32] : gf_ff[s-1];
      end else if (s == afe_pkg::POW_STEPS + 1) begin : g_shift
         logic [9:0] n;
         assign n     = y_ff[s-1][25:16];
         assign gf_in = (big_ff[s-1] || n > 10'd32) ? 33'd0 : (gf_ff[s-1] >> n[5:0]);
      end else begin : g_hold
         assign gf_in = gf_ff[s-1];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            gf_ff[s]   <= gf_in;
            y_ff[s]    <= y_ff[s-1];
            big_ff[s]  <= big_ff[s-1];
            d_ff[s]    <= d_ff[s-1];
            rem_ff[s]  <= rem_in;
            q_ff[s]    <= {q_ff[s-1][31:0], ge};
            mode_ff[s] <= mode_ff[s-1];
         end
      end
   end

   // term magnitude
   logic [32:0] fac;
   logic [64:0] tprod;
   logic [31:0] tm_ff;
   logic        neg_ff;
   logic        ovf1_ff;

   assign fac   = (mode_ff[STEPS] == afe_pkg::REQ_LORENTZIAN) ?
                  (wid_zero ? 33'd0 : q_ff[STEPS]) : gf_ff[STEPS];
   assign tprod = 65'(mag) * 65'(fac);

   always_ff @(posedge clock) begin
      if (en) begin
         tm_ff   <= tprod[63:32];
         neg_ff  <= neg;
         ovf1_ff <= (mode_ff[STEPS] == afe_pkg::REQ_LORENTZIAN) && wid_zero;
      end
   end

   afe_pkg::term_type term_ff;
   logic              ovf_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         term_ff <= neg_ff ? -$signed({1'b0, tm_ff}) : $signed({1'b0, tm_ff});
         ovf_ff  <= ovf1_ff;
      end
   end

   assign term_out = term_ff;
   assign ovf_out  = ovf_ff;

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

class ff_scoreboard;
   logic [63:0]     coeffs[afe_pkg::MAX_TERMS];
   longint unsigned pow_q32[16];
   logic [31:0]     exp_ff[$];
   logic            exp_ovf[$];
   int              errors;

   function new();
      longint unsigned t;
      foreach (coeffs[i]) coeffs[i] = '0;
      errors = 0;
      t = root64(64'h8000_0000_0000_0000);
      pow_q32[15] = t;
      for (int k = 15; k > 0; k--) pow_q32[k-1] = root64(pow_q32[k] << 32);
   endfunction

   function longint unsigned root64(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function longint unsigned decay_q32(longint unsigned x, longint unsigned b);
      longint unsigned p;
      longint unsigned y;
      longint unsigned f;
      longint unsigned n;
      p = (x * b) >> 16;
      if (p >= 64'h1_0000_0000) return 0;
      y = (p * longint'(afe_pkg::EXP2_SCALE)) >> 32;
      f = 64'h1_0000_0000;
      for (int k = 0; k < 16; k++)
         if (y[k]) f = (f * pow_q32[k]) >> 32;
      n = y >> 16;
      if (n > 32) return 0;
      return f >> n;
   endfunction

   function void note(logic kind, logic [31:0] arg);
      longint          sum;
      longint          res;
      logic            ovf;
      logic [31:0]     amp;
      longint unsigned b;
      longint unsigned mag;
      longint unsigned f;
      longint unsigned x;
      sum = 0;
      ovf = 0;
      x = arg;
      for (int i = 0; i < afe_pkg::NUM_TERMS_DEF; i++) begin
         amp = coeffs[i][63:32];
         b   = coeffs[i][31:0];
         mag = amp[31] ? longint'(32'(-amp)) : longint'(amp);
         if (kind == afe_pkg::REQ_GAUSSIAN) begin
            f = decay_q32(x, b);
         end else if (b == 0) begin
            ovf = 1;
            f = 0;
         end else begin
            f = (b << 32) / (b + ((x * x) >> 16));
         end
         if (amp[31]) sum = sum - longint'((mag * f) >> 32);
         else sum = sum + longint'((mag * f) >> 32);
      end
      res = (kind == afe_pkg::REQ_GAUSSIAN) ? 64'sd16777216 - sum : sum;
      if (res > 64'sd2147483647) begin
         res = 64'sd2147483647;
         ovf = 1;
      end
      if (res < -64'sd2147483648) begin
         res = -64'sd2147483648;
         ovf = 1;
      end
      exp_ff.push_back(res[31:0]);
      exp_ovf.push_back(ovf);
   endfunction

   function void check(logic [31:0] ff, logic ovf);
      logic [31:0] eff;
      logic        eovf;
      if (exp_ff.size() == 0) begin
         $display("%0t unexpected word: form_factor %h overflow %b", $time, ff, ovf);
         errors++;
         return;
      end
      eff  = exp_ff.pop_front();
      eovf = exp_ovf.pop_front();
      if (ff !== eff) begin
         $display("%0t form_factor mismatch: expected %h actual %h", $time, eff, ff);
         errors++;
      end
      if (ovf !== eovf) begin
         $display("%0t overflow mismatch: expected %b actual %b", $time, eovf, ovf);
         errors++;
      end
   endfunction
endclass

module tb_top;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = afe_pkg::TOP_LAT + 8;
   localparam logic [2:0] UNUSED_IDX_LO = 3'd6;
   localparam logic [2:0] UNUSED_IDX_HI = 3'd7;

   logic                                     clock = 0;
   logic                                     reset = 1;
   logic                                     req_valid = 0;
   logic                                     req_stall;
   logic                                     req_type = afe_pkg::REQ_GAUSSIAN;
   logic [afe_pkg::ARG_WIDTH-1:0]            req_argument = '0;
   logic                                     rsp_valid;
   logic                                     rsp_stall = 0;
   logic signed [afe_pkg::RESULT_WIDTH-1:0]  rsp_form_factor;
   logic                                     rsp_overflow;
   logic                                     csr_valid = 0;
   logic                                     csr_ready;
   logic [afe_pkg::CSR_INDEX_WIDTH-1:0]      csr_index = '0;
   logic [afe_pkg::COEFF_WIDTH-1:0]          csr_wdata = '0;

   ff_scoreboard sb = new();
   bit           quiet = 0;
   int           idle_cycles = 0;

   atomic_form_factor_eval_top i_dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check(rsp_form_factor, rsp_overflow);
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      int n;
      forever begin
         if (quiet) begin
            rsp_stall <= 0;
            @(posedge clock);
         end else begin
            n = $urandom_range(1, 17);
            rsp_stall <= ($urandom_range(0, 2) == 0);
            repeat (n) @(posedge clock);
         end
      end
   end

   task automatic send_word(logic kind, logic [31:0] arg);
      int gap;
      gap = quiet ? 0 : (($urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1;
      req_type     <= kind;
      req_argument <= arg;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note(kind, arg);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.exp_ff.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_term(logic [2:0] idx, logic [63:0] value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      if (idx < afe_pkg::MAX_TERMS) sb.coeffs[idx] = value;
      @(posedge clock);
   endtask

   function automatic logic [31:0] rand_arg();
      case ($urandom_range(0, 4))
         0: return $urandom();
         1: return $urandom_range(0, 'h3FFFF);
         2: return $urandom() >> $urandom_range(0, 31);
         3: return $urandom_range(0, 'hFFFFF);
         default: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      endcase
   endfunction

   function automatic logic [63:0] rand_coeff();
      logic [31:0] amp;
      logic [31:0] width;
      case ($urandom_range(0, 3))
         0: amp = $urandom();
         1: amp = 32'($urandom_range(0, 'h3FF_FFFF)) - 32'h200_0000;
         2: amp = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: amp = 32'($urandom_range(0, 'h1FF_FFFF)) - 32'h100_0000;
      endcase
      case ($urandom_range(0, 7))
         0: width = 0;
         1: width = $urandom();
         2: width = $urandom() >> $urandom_range(0, 31);
         default: width = $urandom_range(1, 'h3F_FFFF);
      endcase
      return {amp, width};
   endfunction

   initial begin
      logic [31:0] dir_args[8];
      dir_args = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h1_0000, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'h2_0000, 32'h0000_FFFF};
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // registers at reset value
      send_word(afe_pkg::REQ_GAUSSIAN, 32'h0);
      send_word(afe_pkg::REQ_LORENTZIAN, 32'h1_0000);
      drain();

      // mixed terms: zero width, extreme amplitudes and widths
      write_term(3'd0, {32'h0100_0000, 32'h0001_0000});
      write_term(3'd1, {32'hFF80_0000, 32'h0000_0000});
      write_term(3'd2, {32'h7FFF_FFFF, 32'hFFFF_FFFF});
      write_term(3'd3, {32'h8000_0000, 32'h0000_0001});
      write_term(3'd4, {32'h0080_0000, 32'h0020_0000});
      write_term(3'd5, {32'hFFF0_0000, 32'h000A_0000});
      foreach (dir_args[i]) begin
         send_word(afe_pkg::REQ_GAUSSIAN, dir_args[i]);
         send_word(afe_pkg::REQ_LORENTZIAN, dir_args[i]);
      end
      drain();

      // saturation in both directions; unused indexes must be ignored
      for (int i = 0; i < afe_pkg::MAX_TERMS; i++)
         write_term(3'(i), {32'h7FFF_FFFF, 32'hFFFF_FFFF});
      write_term(UNUSED_IDX_LO, 64'h0);
      write_term(UNUSED_IDX_HI, 64'hFFFF_FFFF_FFFF_FFFF);
      send_word(afe_pkg::REQ_LORENTZIAN, 32'h0);
      send_word(afe_pkg::REQ_GAUSSIAN, 32'h0);
      send_word(afe_pkg::REQ_GAUSSIAN, 32'hFFFF_FFFF);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         if (ph == 1) begin
            for (int i = 0; i < afe_pkg::MAX_TERMS; i++)
               write_term(3'(i), {32'h8000_0000, 32'h0000_0001});
         end else begin
            for (int i = 0; i < afe_pkg::MAX_TERMS; i++) write_term(3'(i), rand_coeff());
            write_term($urandom_range(0, 1) ? UNUSED_IDX_LO : UNUSED_IDX_HI,
                       {$urandom(), $urandom()});
         end
         if (ph == 7) quiet = 1;
         for (int k = 0; k < 175; k++) send_word(1'($urandom_range(0, 1)), rand_arg());
         drain();
      end

      if (sb.errors == 0 && sb.exp_ff.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
